// ----- rtl/integer_alu_overflow_trap_core_defines.svh -----
// Assertion macros shared by the checker of the integer ALU core.
`ifndef INTEGER_ALU_OVERFLOW_TRAP_CORE_DEFINES_SVH
`define INTEGER_ALU_OVERFLOW_TRAP_CORE_DEFINES_SVH

// Same-cycle implication, silent while reset is held.
`define IAOT_ASSERT_SAME(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("same-cycle check failed");

// Next-cycle implication, silent while reset is held.
`define IAOT_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("next-cycle check failed");

// Next-cycle implication that is also checked during reset.
`define IAOT_ASSERT_ALWAYS_NEXT(lbl, clk, pre, post) \
    lbl: assert property (@(posedge clk) (pre) |=> (post)) \
        else $error("reset check failed");

`endif

// ----- rtl/iaot_pkg.sv -----
// Types, codes and helper functions of the integer ALU core.
`default_nettype none

package iaot_pkg;

    localparam int WORD_W      = 32;
    localparam int OPC_W       = 5;
    localparam int KIND_W      = 3;
    localparam int DIV_STEPS   = WORD_W;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 40;

    localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [OPC_W-1:0] {
        OP_ADD  = 5'd0,
        OP_ADDI = 5'd1,
        OP_SUB  = 5'd2,
        OP_SLT  = 5'd3,
        OP_SLTI = 5'd4,
        OP_MUL  = 5'd5,
        OP_DIV  = 5'd6,
        OP_REM  = 5'd7,
        OP_AND  = 5'd8,
        OP_ANDI = 5'd9,
        OP_OR   = 5'd10,
        OP_ORI  = 5'd11,
        OP_XOR  = 5'd12,
        OP_XORI = 5'd13,
        OP_BEQ  = 5'd14,
        OP_BNE  = 5'd15,
        OP_BLT  = 5'd16,
        OP_BLE  = 5'd17
    } t_opcode;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADDER   = 3'd0,
        KIND_BRANCH  = 3'd1,
        KIND_DIVIDER = 3'd2,
        KIND_LOGIC   = 3'd3,
        KIND_MULT    = 3'd4
    } t_kind;

    // How the final result of an item is formed.
    typedef enum logic [1:0] {
        SEL_PLAIN,
        SEL_MUL,
        SEL_QUO,
        SEL_REM
    } t_sel;

    // Payload that travels down the pipeline.
    typedef struct packed {
        t_sel              sel;
        logic [WORD_W-1:0] res;
        logic              flag;
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] quo;
        logic [WORD_W-1:0] dvs;
        logic              neg_q;
        logic              neg_r;
    } t_stage;

    // One restoring division step: shift in one dividend bit, try a subtract.
    function automatic t_stage div_step(input t_stage s);
        logic [WORD_W:0]   trial;
        logic [WORD_W+1:0] diff;
        t_stage            o;
        o     = s;
        trial = {s.rem, s.quo[WORD_W-1]};
        diff  = {1'b0, trial} - {2'b00, s.dvs};
        if (!diff[WORD_W+1]) begin
            o.rem = diff[WORD_W-1:0];
            o.quo = {s.quo[WORD_W-2:0], 1'b1};
        end else begin
            o.rem = trial[WORD_W-1:0];
            o.quo = {s.quo[WORD_W-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/integer_alu_overflow_trap_core.sv -----
// Top level of the pipelined signed 32-bit integer ALU with overflow trap.
//
//  Channel   | Direction | Handshake              | Payload (lowest bit first)
//  s_axis    | in        | tvalid / tready        | opcode, first_operand, second_operand
//  m_axis    | out       | tvalid / tready        | result_word, exception_flag
//  cfg       | in        | i_cfg_valid/o_cfg_ready| unit_kind
//
// One item is accepted per cycle while the skid register is empty; a result beat passes
// the input register, stages 2 and 3, the divider array and the output register in turn.
// The pipeline depth is set by the divider array, which retires one quotient bit per stage.
// Reset is synchronous and clears all valid bits and the unit kind to adder.
// The pipeline moves as one; it holds only while the output skid register is full,
// and s_axis_tready comes straight from that register.
`default_nettype none

module integer_alu_overflow_trap_core (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // opcode [4:0], first_operand [36:5], second_operand [68:37], zero pad
    input  wire  [iaot_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // result_word [31:0], exception_flag [32], zero pad
    output logic [iaot_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [iaot_pkg::KIND_W-1:0]         i_cfg_data
);

    localparam int W  = iaot_pkg::WORD_W;
    localparam int NS = iaot_pkg::DIV_STEPS;

    logic                      adv;
    logic [iaot_pkg::KIND_W-1:0] r_unit_kind;

    logic                      r1_valid;
    logic [iaot_pkg::OPC_W-1:0] r1_op;
    logic [W-1:0]              r1_a;
    logic [W-1:0]              r1_b;

    logic                      r2_valid;
    iaot_pkg::t_stage          r2_st;
    logic signed [2*W-1:0]     r2_prod;

    logic                      r3_valid;
    iaot_pkg::t_stage          r3_st;

    logic [NS-1:0]             r_div_valid;
    iaot_pkg::t_stage          r_div [NS];

    logic                      r_out_valid;
    logic [W:0]                r_out;
    logic                      r_skid_valid;
    logic [W:0]                r_skid;

    iaot_pkg::t_stage          n2_st;
    logic signed [2*W-1:0]     n2_prod;
    iaot_pkg::t_stage          n3_st;
    logic [W:0]                n_fin;
    logic [W:0]                sum_ext;
    logic [W:0]                dif_ext;
    logic                      add_ovf;
    logic                      sub_ovf;
    logic                      lt;
    logic                      eq;
    logic                      mul_fits;
    logic [W-1:0]              quo_s;
    logic                      quo_ovf;
    logic                      push;

    // The pipeline advances whenever the skid register has room.
    assign adv           = !r_skid_valid;
    assign s_axis_tready = adv;
    assign o_cfg_ready   = 1'b1;
    assign push          = r_div_valid[NS-1] && adv;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_kind <= iaot_pkg::KIND_ADDER;
        end else if (i_cfg_valid) begin
            r_unit_kind <= i_cfg_data;
        end
    end

    // Stage 2 logic: add, compare, logic, multiply and divider operand setup.
    always_comb begin
        sum_ext = {r1_a[W-1], r1_a} + {r1_b[W-1], r1_b};
        dif_ext = {r1_a[W-1], r1_a} - {r1_b[W-1], r1_b};
        add_ovf = sum_ext[W] != sum_ext[W-1];
        sub_ovf = dif_ext[W] != dif_ext[W-1];
        lt      = $signed(r1_a) < $signed(r1_b);
        eq      = r1_a == r1_b;
        n2_prod = $signed(r1_a) * $signed(r1_b);

        n2_st       = '0;
        n2_st.sel   = iaot_pkg::SEL_PLAIN;
        n2_st.quo   = r1_a[W-1] ? (~r1_a + 1'b1) : r1_a;
        n2_st.dvs   = r1_b[W-1] ? (~r1_b + 1'b1) : r1_b;
        n2_st.neg_q = r1_a[W-1] ^ r1_b[W-1];
        n2_st.neg_r = r1_a[W-1];

        unique case (r_unit_kind)
            iaot_pkg::KIND_ADDER: begin
                unique case (r1_op) inside
                    iaot_pkg::OP_ADD, iaot_pkg::OP_ADDI: begin
                        n2_st.res  = add_ovf ? '0 : sum_ext[W-1:0];
                        n2_st.flag = add_ovf;
                    end
                    iaot_pkg::OP_SUB: begin
                        n2_st.res  = sub_ovf ? '0 : dif_ext[W-1:0];
                        n2_st.flag = sub_ovf;
                    end
                    iaot_pkg::OP_SLT, iaot_pkg::OP_SLTI: begin
                        n2_st.res = {{(W-1){1'b0}}, lt};
                    end
                    default: ;
                endcase
            end
            iaot_pkg::KIND_BRANCH: begin
                unique case (r1_op)
                    iaot_pkg::OP_BEQ: n2_st.res = {{(W-1){1'b0}}, eq};
                    iaot_pkg::OP_BNE: n2_st.res = {{(W-1){1'b0}}, !eq};
                    iaot_pkg::OP_BLT: n2_st.res = {{(W-1){1'b0}}, lt};
                    iaot_pkg::OP_BLE: n2_st.res = {{(W-1){1'b0}}, lt || eq};
                    default: ;
                endcase
            end
            iaot_pkg::KIND_DIVIDER: begin
                // A zero divisor traps whatever the opcode.
                if (r1_b == '0) begin
                    n2_st.flag = 1'b1;
                end else if (r1_op == iaot_pkg::OP_DIV) begin
                    n2_st.sel = iaot_pkg::SEL_QUO;
                end else if (r1_op == iaot_pkg::OP_REM) begin
                    n2_st.sel = iaot_pkg::SEL_REM;
                end
            end
            iaot_pkg::KIND_LOGIC: begin
                unique case (r1_op) inside
                    iaot_pkg::OP_AND, iaot_pkg::OP_ANDI: n2_st.res = r1_a & r1_b;
                    iaot_pkg::OP_OR,  iaot_pkg::OP_ORI:  n2_st.res = r1_a | r1_b;
                    iaot_pkg::OP_XOR, iaot_pkg::OP_XORI: n2_st.res = r1_a ^ r1_b;
                    default: ;
                endcase
            end
            iaot_pkg::KIND_MULT: begin
                if (r1_op == iaot_pkg::OP_MUL) begin
                    n2_st.sel = iaot_pkg::SEL_MUL;
                end
            end
            default: ;
        endcase
    end

    // Stage 3 logic: the product fits when its upper bits are all copies of bit 31.
    always_comb begin
        mul_fits = (&r2_prod[2*W-1:W-1]) || !(|r2_prod[2*W-1:W-1]);
        n3_st    = r2_st;
        if (r2_st.sel == iaot_pkg::SEL_MUL) begin
            n3_st.sel  = iaot_pkg::SEL_PLAIN;
            n3_st.res  = mul_fits ? r2_prod[W-1:0] : '0;
            n3_st.flag = !mul_fits;
        end
    end

    // Final logic: restore signs of quotient and remainder, trap the one overflow.
    always_comb begin
        quo_s   = r_div[NS-1].neg_q ? (~r_div[NS-1].quo + 1'b1) : r_div[NS-1].quo;
        quo_ovf = !r_div[NS-1].neg_q && (r_div[NS-1].quo == iaot_pkg::WORD_MIN);
        case (r_div[NS-1].sel)
            iaot_pkg::SEL_QUO: n_fin = {quo_ovf, quo_ovf ? {W{1'b0}} : quo_s};
            iaot_pkg::SEL_REM: n_fin = {1'b0, r_div[NS-1].neg_r ?
                                        (~r_div[NS-1].rem + 1'b1) : r_div[NS-1].rem};
            default:           n_fin = {r_div[NS-1].flag, r_div[NS-1].res};
        endcase
    end

    // Valid bits of the pipeline stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_div_valid <= '0;
        end else if (adv) begin
            r1_valid    <= s_axis_tvalid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r_div_valid <= {r_div_valid[NS-2:0], r3_valid};
        end
    end

    // Payload of the pipeline stages, one quotient bit per divider stage.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_op    <= s_axis_tdata[iaot_pkg::OPC_W-1:0];
            r1_a     <= s_axis_tdata[iaot_pkg::OPC_W +: W];
            r1_b     <= s_axis_tdata[iaot_pkg::OPC_W+W +: W];
            r2_st    <= n2_st;
            r2_prod  <= n2_prod;
            r3_st    <= n3_st;
            r_div[0] <= iaot_pkg::div_step(r3_st);
            for (int k = 1; k < NS; k++) begin
                r_div[k] <= iaot_pkg::div_step(r_div[k-1]);
            end
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= push;
            end
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_axis_tready) begin
            r_out <= r_skid_valid ? r_skid : n_fin;
        end else if (push) begin
            r_skid <= n_fin;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(iaot_pkg::OUT_TDATA_W-W-1){1'b0}}, r_out};

endmodule

`default_nettype wire

// ----- rtl/iaot_checker.sv -----
// Port-level checker of the integer ALU core, bound to its top level.
`default_nettype none
`include "integer_alu_overflow_trap_core_defines.svh"

module iaot_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              s_axis_tready,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [iaot_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    logic out_stall;
    logic trap_beat;

    // Result beat held by the sink, and result beat that carries a trap.
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign trap_beat = m_axis_tvalid && m_axis_tdata[iaot_pkg::WORD_W];

    // A stalled result beat holds its valid and its data.
    `IAOT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

    // A trapped result always carries a zero word.
    `IAOT_ASSERT_SAME(a_trap_zero, i_clk, i_rst_n, trap_beat, m_axis_tdata[iaot_pkg::WORD_W-1:0] == '0)

    // Input back-pressure only comes from a held output with a full skid register.
    `IAOT_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid)

    // Once the output beat is taken, the skid drains and input opens again.
    `IAOT_ASSERT_NEXT(a_skid_drain, i_clk, i_rst_n, !s_axis_tready && m_axis_tready, s_axis_tready)

    // Reset leaves no result on the output.
    `IAOT_ASSERT_ALWAYS_NEXT(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid && s_axis_tready)

endmodule

bind integer_alu_overflow_trap_core iaot_checker u_iaot_checker (.*);

`default_nettype wire
